// File: design/pmgf_pkg.sv
// ----------------------------------------------------------------------------
// pmgf_pkg: shared types and constants of the pose median gate filter
// Widths, register indexes, channel payload types and the median helper.
// ----------------------------------------------------------------------------
package pmgf_pkg;

  localparam int unsigned Window   = 5;
  localparam int unsigned PosWidth = 24;
  localparam int unsigned RotWidth = 16;
  localparam int unsigned CfgWidth = 23;
  localparam int unsigned IdxWidth = 2;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [IdxWidth-1:0] {
    REG_TOLERANCE = 2'd0,
    REG_REF_EN    = 2'd1,
    REG_BOUND_X   = 2'd2,
    REG_BOUND_Y   = 2'd3
  } reg_idx_e;

  typedef logic signed [PosWidth-1:0] pos_t;
  typedef logic signed [RotWidth-1:0] rot_t;

  typedef struct packed {
    logic mode;
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;
    rot_t quat_w;
    rot_t quat_x;
    rot_t quat_y;
    rot_t quat_z;
    logic sample_valid;
  } in_item_t;

  typedef struct packed {
    pos_t median_x;
    pos_t median_y;
    pos_t median_z;
    rot_t median_qw;
    rot_t median_qx;
    rot_t median_qy;
    rot_t median_qz;
    logic inside_area;
    logic reference_match;
    logic filtered_ok;
    logic raw_ok;
  } out_item_t;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic is_ref;
    pos_t med_x;
    pos_t med_y;
    pos_t med_z;
    rot_t med_qw;
    rot_t med_qx;
    rot_t med_qy;
    rot_t med_qz;
    pos_t ref_x;
    pos_t ref_y;
    logic last_valid;
  } work_t;

  typedef struct packed {
    logic [CfgWidth-1:0] tolerance;
    logic                ref_en;
    logic [CfgWidth-1:0] bound_x;
    logic [CfgWidth-1:0] bound_y;
  } cfg_t;

  // Median by rank count; every comparison is independent.
  function automatic logic signed [PosWidth-1:0] median5(
      input logic signed [Window-1:0][PosWidth-1:0] v);
    logic signed [PosWidth-1:0] res;
    int unsigned less;
    int unsigned eq;
    res = v[0];
    for (int i = Window - 1; i >= 0; i--) begin
      less = 0;
      eq = 0;
      for (int j = 0; j < Window; j++) begin
        if ($signed(v[j]) < $signed(v[i])) less++;
        else if (v[j] == v[i]) eq++;
      end
      if (less <= Window / 2 && Window / 2 < less + eq) res = v[i];
    end
    return res;
  endfunction

endpackage

// File: design/pmgf_if.sv
// ----------------------------------------------------------------------------
// pmgf channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface pmgf_in_if;
  logic               valid;
  logic               ready;
  pmgf_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pmgf_out_if;
  logic                valid;
  logic                ready;
  pmgf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pmgf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pmgf_pkg::IdxWidth-1:0]       index;
  logic [pmgf_pkg::DataWidth-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/pmgf_front.sv
// ----------------------------------------------------------------------------
// pmgf_front: history window and median network
// Shift tracker samples into the window and register the seven medians.
// ----------------------------------------------------------------------------
module pmgf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pmgf_pkg::in_item_t in_data_i,
  output logic               wk_valid_o,
  input  logic               wk_ready_i,
  output pmgf_pkg::work_t    wk_data_o
);

  localparam int unsigned W = pmgf_pkg::Window;

  logic signed [W-1:0][pmgf_pkg::PosWidth-1:0] hx_q, hy_q, hz_q;
  logic signed [W-1:0][pmgf_pkg::RotWidth-1:0] hw_q, hqx_q, hqy_q, hqz_q;
  logic signed [W-1:0][pmgf_pkg::PosWidth-1:0] hx_d, hy_d, hz_d;
  logic signed [W-1:0][pmgf_pkg::RotWidth-1:0] hw_d, hqx_d, hqy_d, hqz_d;
  logic signed [W-1:0][pmgf_pkg::PosWidth-1:0] ew, eqx, eqy, eqz;
  logic last_valid_q, last_valid_d;
  logic stage_valid_q;
  pmgf_pkg::work_t stage_q, stage_d;
  logic accept;

  assign in_ready_o = !stage_valid_q || wk_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hx_d = hx_q; hy_d = hy_q; hz_d = hz_q;
    hw_d = hw_q; hqx_d = hqx_q; hqy_d = hqy_q; hqz_d = hqz_q;
    last_valid_d = last_valid_q;
    if (!in_data_i.mode) begin
      for (int i = 0; i < W - 1; i++) begin
        hx_d[i] = hx_q[i+1]; hy_d[i] = hy_q[i+1]; hz_d[i] = hz_q[i+1];
        hw_d[i] = hw_q[i+1]; hqx_d[i] = hqx_q[i+1];
        hqy_d[i] = hqy_q[i+1]; hqz_d[i] = hqz_q[i+1];
      end
      hx_d[W-1] = in_data_i.pos_x;
      hy_d[W-1] = in_data_i.pos_y;
      hz_d[W-1] = in_data_i.pos_z;
      hw_d[W-1] = in_data_i.quat_w;
      hqx_d[W-1] = in_data_i.quat_x;
      hqy_d[W-1] = in_data_i.quat_y;
      hqz_d[W-1] = in_data_i.quat_z;
      last_valid_d = in_data_i.sample_valid;
    end
    // Sign-extend rotation lanes so one median function serves all channels.
    for (int i = 0; i < W; i++) begin
      ew[i]  = pmgf_pkg::PosWidth'($signed(hw_d[i]));
      eqx[i] = pmgf_pkg::PosWidth'($signed(hqx_d[i]));
      eqy[i] = pmgf_pkg::PosWidth'($signed(hqy_d[i]));
      eqz[i] = pmgf_pkg::PosWidth'($signed(hqz_d[i]));
    end
    stage_d.is_ref     = in_data_i.mode;
    stage_d.med_x      = pmgf_pkg::median5(hx_d);
    stage_d.med_y      = pmgf_pkg::median5(hy_d);
    stage_d.med_z      = pmgf_pkg::median5(hz_d);
    stage_d.med_qw     = pmgf_pkg::RotWidth'(pmgf_pkg::median5(ew));
    stage_d.med_qx     = pmgf_pkg::RotWidth'(pmgf_pkg::median5(eqx));
    stage_d.med_qy     = pmgf_pkg::RotWidth'(pmgf_pkg::median5(eqy));
    stage_d.med_qz     = pmgf_pkg::RotWidth'(pmgf_pkg::median5(eqz));
    stage_d.ref_x      = in_data_i.pos_x;
    stage_d.ref_y      = in_data_i.pos_y;
    stage_d.last_valid = last_valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hx_q <= '0; hy_q <= '0; hz_q <= '0;
      hw_q <= '0; hqx_q <= '0; hqy_q <= '0; hqz_q <= '0;
      last_valid_q  <= 1'b0;
      stage_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        hx_q <= hx_d; hy_q <= hy_d; hz_q <= hz_d;
        hw_q <= hw_d; hqx_q <= hqx_d; hqy_q <= hqy_d; hqz_q <= hqz_d;
        last_valid_q <= last_valid_d;
        stage_valid_q <= 1'b1;
      end else if (wk_ready_i) begin
        stage_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) stage_q <= stage_d;
  end

  assign wk_valid_o = stage_valid_q;
  assign wk_data_o  = stage_q;

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q && !wk_ready_i |=> stage_valid_q && $stable(stage_q))
    else $error("front stage dropped a pending item");
  a_ref_keeps_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.mode |=> $stable(hx_q) && $stable(last_valid_q))
    else $error("reference event changed history");
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q && !wk_ready_i |-> !in_ready_o)
    else $error("front accepted into a full stage");

endmodule

// File: design/pmgf_queue.sv
// ----------------------------------------------------------------------------
// pmgf_queue: short FIFO between front and back
// Two-entry register queue so each side stalls on its own.
// ----------------------------------------------------------------------------
module pmgf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  pmgf_pkg::work_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output pmgf_pkg::work_t rd_data_o
);

  localparam int unsigned D = pmgf_pkg::QueueDepth;
  localparam int unsigned PW = $clog2(D);

  pmgf_pkg::work_t    mem_q [D];
  logic [PW-1:0]      wp_q, rp_q;
  logic [PW:0]        cnt_q;
  logic               push, pop;

  assign wr_ready_o = cnt_q != (PW+1)'(D);
  assign rd_valid_o = cnt_q != '0;
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PW'(D - 1)) ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= (rp_q == PW'(D - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(D)) else $error("queue count overflow");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count slip");
  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !pop) else $error("queue popped when empty");

endmodule

// File: design/pmgf_back.sv
// ----------------------------------------------------------------------------
// pmgf_back: gates and flags
// Area check, reference distance check and flag state; registers the result.
// ----------------------------------------------------------------------------
module pmgf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pmgf_pkg::cfg_t      cfg_i,
  input  logic                wk_valid_i,
  output logic                wk_ready_o,
  input  pmgf_pkg::work_t     wk_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pmgf_pkg::out_item_t out_data_o
);

  localparam int unsigned PW = pmgf_pkg::PosWidth;

  logic inside_q, inside_d, match_q, match_d;
  logic ov_q;
  pmgf_pkg::out_item_t od_q, od_d;
  logic take;
  logic signed [PW:0] dx, dy;
  logic signed [2*PW+1:0] dxx, dyy;
  logic [2*PW+1:0] d2;
  logic [2*pmgf_pkg::CfgWidth-1:0] t2;
  logic signed [PW:0] bx, by;

  assign wk_ready_o = !ov_q || out_ready_i;
  assign take = wk_valid_i && wk_ready_o;

  always_comb begin
    dx = (PW+1)'(wk_data_i.ref_x) - (PW+1)'(wk_data_i.med_x);
    dy = (PW+1)'(wk_data_i.ref_y) - (PW+1)'(wk_data_i.med_y);
    // Full-width squares: each product is non-negative and fits below 2^49.
    dxx = dx * dx;
    dyy = dy * dy;
    d2 = $unsigned(dxx) + $unsigned(dyy);
    t2 = cfg_i.tolerance * cfg_i.tolerance;
    bx = (PW+1)'({1'b0, cfg_i.bound_x});
    by = (PW+1)'({1'b0, cfg_i.bound_y});
    inside_d = inside_q;
    match_d  = match_q;
    if (!wk_data_i.is_ref) begin
      inside_d = wk_data_i.med_x > 0 && (PW+1)'(wk_data_i.med_x) < bx &&
                 wk_data_i.med_y > 0 && (PW+1)'(wk_data_i.med_y) < by;
    end else begin
      match_d = !(cfg_i.ref_en && d2 > (2*PW+2)'(t2));
    end
    od_d.median_x  = wk_data_i.med_x;
    od_d.median_y  = wk_data_i.med_y;
    od_d.median_z  = wk_data_i.med_z;
    od_d.median_qw = wk_data_i.med_qw;
    od_d.median_qx = wk_data_i.med_qx;
    od_d.median_qy = wk_data_i.med_qy;
    od_d.median_qz = wk_data_i.med_qz;
    od_d.inside_area     = inside_d;
    od_d.reference_match = match_d;
    od_d.filtered_ok     = wk_data_i.last_valid && inside_d && match_d;
    od_d.raw_ok          = wk_data_i.last_valid && inside_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b1;
      match_q  <= 1'b1;
      ov_q     <= 1'b0;
    end else begin
      if (take) begin
        inside_q <= inside_d;
        match_q  <= match_d;
        ov_q     <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) od_q <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  a_filt_implies_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && od_q.filtered_ok |-> od_q.raw_ok) else $error("filtered without raw");
  a_ref_keeps_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && wk_data_i.is_ref |=> inside_q == $past(inside_q))
    else $error("reference event changed area flag");
  a_flags_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> od_q.inside_area == inside_q && od_q.reference_match == match_q)
    else $error("result flags differ from state");

endmodule

// File: design/pose_median_gate_filter_top.sv
// ----------------------------------------------------------------------------
// pose_median_gate_filter_top: five-sample median pose filter with gates
// Register file, median front end, queue and gate back end.
// ----------------------------------------------------------------------------
// Path: an input beat passes the front stage, a queue entry and the back stage,
//   each registered, before the result beat; items waiting in the queue delay it.
// Throughput: one beat per cycle while out_if.ready holds; the median network and
//   the distance multipliers are each one register stage.
// Reset: rst_ni clears history, flags (inside and match to one) and registers
//   to their defaults; no clearing pass.
module pose_median_gate_filter_top (
  input logic        clk_i,
  input logic        rst_ni,
  pmgf_in_if.sink    in_if,
  pmgf_out_if.source out_if,
  pmgf_cfg_if.sink   cfg_if
);

  pmgf_pkg::cfg_t  cfg_q;
  pmgf_pkg::work_t f_data, q_data;
  logic            f_valid, f_ready, q_valid, q_ready;

  // Register writes are always taken; unknown indexes fall to the default arm.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance <= pmgf_pkg::CfgWidth'(6554);
      cfg_q.ref_en    <= 1'b1;
      cfg_q.bound_x   <= pmgf_pkg::CfgWidth'(196608);
      cfg_q.bound_y   <= pmgf_pkg::CfgWidth'(131072);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        pmgf_pkg::REG_TOLERANCE: cfg_q.tolerance <= cfg_if.data[pmgf_pkg::CfgWidth-1:0];
        pmgf_pkg::REG_REF_EN:    cfg_q.ref_en    <= cfg_if.data[0];
        pmgf_pkg::REG_BOUND_X:   cfg_q.bound_x   <= cfg_if.data[pmgf_pkg::CfgWidth-1:0];
        pmgf_pkg::REG_BOUND_Y:   cfg_q.bound_y   <= cfg_if.data[pmgf_pkg::CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  // Front: shift history, register medians.
  pmgf_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready), .in_data_i (in_if.data),
    .wk_valid_o (f_valid), .wk_ready_i (f_ready), .wk_data_o (f_data)
  );

  // Queue decouples median stage from gate stage.
  pmgf_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid), .wr_ready_o (f_ready), .wr_data_i (f_data),
    .rd_valid_o (q_valid), .rd_ready_i (q_ready), .rd_data_o (q_data)
  );

  // Back: advance flags, hold the result beat until taken.
  pmgf_back u_back (
    .clk_i, .rst_ni, .cfg_i (cfg_q),
    .wk_valid_i (q_valid), .wk_ready_o (q_ready), .wk_data_i (q_data),
    .out_valid_o (out_if.valid), .out_ready_i (out_if.ready), .out_data_o (out_if.data)
  );

endmodule
